@@ rtl/dds_command_serializer_core_defines.svh @@
// assertion macros for the dds command serializer
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef DDS_COMMAND_SERIALIZER_CORE_DEFINES_SVH
`define DDS_COMMAND_SERIALIZER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dcs_pkg.sv @@
// shared types and constants of the dds command serializer
// no dependencies
`default_nettype none

package dcs_pkg;

  // system clock of the dds and the frequency limit
  localparam int unsigned SYS_CLOCK_HZ = 500000000;
  localparam logic [27:0] FREQ_LIMIT_HZ = 28'd200000000;

  // raw write byte limit, never above the four bytes of raw_data
  localparam int unsigned MAX_RAW_BYTES = 4;
  localparam int unsigned RAW_LIMIT     = (MAX_RAW_BYTES < 4) ? MAX_RAW_BYTES : 4;

  // tuning word: frequency times a 96-bit reciprocal of the clock scaled by 2^89,
  // one 32-bit slice a cycle; exact while 200 MHz times the clock stays below 2^57
  localparam int unsigned TW_W     = 32;
  localparam int unsigned TW_SHIFT = 57;
  localparam int unsigned TW_STEPS = 3;
  localparam int unsigned TW_CNT_W = 2;
  localparam int unsigned TW_ACC_W = TW_W + TW_SHIFT;
  localparam logic [96:0] TW_NUM   = 97'd1 << (TW_W + TW_SHIFT);
  localparam logic [95:0] TW_RECIP =
    96'((TW_NUM + 97'(SYS_CLOCK_HZ) - 97'd1) / 97'(SYS_CLOCK_HZ));

  // frame shifter: instruction byte plus up to four data bytes
  localparam int unsigned FRAME_W  = 40;
  localparam int unsigned BITCNT_W = 6;

  localparam logic [BITCNT_W-1:0] BITS_CHAN  = BITCNT_W'(16);
  localparam logic [BITCNT_W-1:0] BITS_FREQ  = BITCNT_W'(40);
  localparam logic [BITCNT_W-1:0] BITS_PHASE = BITCNT_W'(24);
  localparam logic [BITCNT_W-1:0] BITS_AMPL  = BITCNT_W'(32);

  // device register addresses
  localparam logic [7:0] REG_CHAN_SEL   = 8'h00;
  localparam logic [7:0] REG_FREQ_WORD  = 8'h04;
  localparam logic [7:0] REG_PHASE_WORD = 8'h05;
  localparam logic [7:0] REG_AMPL_CTRL  = 8'h06;
  localparam logic [15:0] AMPL_ENABLE   = 16'h1000;

  typedef enum logic [1:0] {
    CMD_FREQ  = 2'd0,
    CMD_PHASE = 2'd1,
    CMD_AMPL  = 2'd2,
    CMD_RAW   = 2'd3
  } cmd_e;

  typedef enum logic {
    FRAME_FIRST  = 1'b0,
    FRAME_SECOND = 1'b1
  } frame_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD1,
    ST_SEND1,
    ST_LOAD2,
    ST_SEND2
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  channel_select;
    logic [27:0] frequency_hz;
    logic [13:0] phase_word;
    logic [9:0]  amplitude_word;
    logic [7:0]  raw_address;
    logic [2:0]  raw_byte_count;
    logic [31:0] raw_data;
    logic        raw_update;
  } dcs_cmd_t;

  // controller to datapath
  typedef struct packed {
    logic       load_cmd;
    logic       load_frame;
    frame_sel_e sel;
    logic       shift;
  } dcs_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic last_bit;
    logic is_raw;
    logic div_done;
    logic out_free;
  } dcs_stat_t;

endpackage

`default_nettype wire

@@ rtl/dcs_tuning_div.sv @@
// frequency tuning word as frequency times a fixed reciprocal of the clock,
// one 28 by 32 bit slice product a cycle over the three reciprocal slices; depends on dcs_pkg
`default_nettype none

module dcs_tuning_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [27:0]               freq_i,
  output logic                           done_o,
  output logic [dcs_pkg::TW_W-1:0]       word_o
);
  import dcs_pkg::*;

  logic [TW_CNT_W-1:0] cnt_q, cnt_d;
  logic [27:0]         f_q, f_d;
  logic [TW_ACC_W-1:0] acc_q, acc_d;
  logic                sat_q, sat_d;
  logic [27:0]         f_sat;
  logic [31:0]         recip_part;
  logic [59:0]         prod;

  always_comb begin
    f_sat = (freq_i > FREQ_LIMIT_HZ) ? FREQ_LIMIT_HZ : freq_i;
    // most significant slice of the reciprocal first
    case (cnt_q)
      2'd3:    recip_part = TW_RECIP[95:64];
      2'd2:    recip_part = TW_RECIP[63:32];
      2'd1:    recip_part = TW_RECIP[31:0];
      default: recip_part = 32'h0;
    endcase
    prod   = 60'(f_q) * 60'(recip_part);
    cnt_d  = cnt_q;
    f_d    = f_q;
    acc_d  = acc_q;
    sat_d  = sat_q;
    if (start_i) begin
      // word only overflows 32 bits when f is not below the clock
      cnt_d = TW_CNT_W'(TW_STEPS);
      f_d   = f_sat;
      acc_d = '0;
      sat_d = (32'(f_sat) >= 32'(SYS_CLOCK_HZ));
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - TW_CNT_W'(1);
      acc_d = {acc_q[TW_ACC_W-33:0], 32'h0} + TW_ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    acc_q <= acc_d;
    sat_q <= sat_d;
  end

  assign done_o = (cnt_q == '0);
  assign word_o = sat_q ? '1 : acc_q[TW_ACC_W-1 -: TW_W];

endmodule

`default_nettype wire

@@ rtl/dcs_datapath.sv @@
// command latch, frame builder, bit shifter and output register
// depends on dcs_pkg and dcs_tuning_div
`default_nettype none

module dcs_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dcs_pkg::dcs_cmd_t  cmd_i,
  input  wire dcs_pkg::dcs_ctrl_t ctrl_i,
  output dcs_pkg::dcs_stat_t      stat_o,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic                    out_bit_o,
  output logic                    out_start_o,
  output logic                    out_end_o,
  output logic                    out_upd_o,
  output logic                    out_last_o
);
  import dcs_pkg::*;

  dcs_cmd_t            cmd_q;
  logic [FRAME_W-1:0]  sr_q, sr_d;
  logic [BITCNT_W-1:0] bits_q, bits_d;
  logic                first_q, first_d;
  logic                upd_q, upd_d;
  logic                final_q, final_d;
  logic                out_valid_q, out_valid_d;
  logic                out_bit_q, out_start_q, out_end_q, out_upd_q, out_last_q;
  logic                div_done;
  logic [TW_W-1:0]     tw;
  logic [2:0]          raw_cnt;
  logic [31:0]         raw_al;
  logic [15:0]         ampl_val;

  dcs_tuning_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl_i.load_cmd),
    .freq_i  (cmd_i.frequency_hz),
    .done_o  (div_done),
    .word_o  (tw)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      cmd_q <= cmd_i;
    end
  end

  // raw data bytes left-aligned so the shifter sends them msb first
  always_comb begin
    raw_cnt = (cmd_q.raw_byte_count > 3'(RAW_LIMIT)) ? 3'(RAW_LIMIT) : cmd_q.raw_byte_count;
    case (raw_cnt)
      3'd0:    raw_al = 32'h0;
      3'd1:    raw_al = {cmd_q.raw_data[7:0], 24'h0};
      3'd2:    raw_al = {cmd_q.raw_data[15:0], 16'h0};
      3'd3:    raw_al = {cmd_q.raw_data[23:0], 8'h0};
      default: raw_al = cmd_q.raw_data;
    endcase
    ampl_val = AMPL_ENABLE | 16'(cmd_q.amplitude_word);
  end

  always_comb begin
    sr_d        = sr_q;
    bits_d      = bits_q;
    first_d     = first_q;
    upd_d       = upd_q;
    final_d     = final_q;
    out_valid_d = out_valid_q;
    if (ctrl_i.load_frame) begin
      first_d = 1'b1;
      if (ctrl_i.sel == FRAME_FIRST) begin
        if (cmd_q.cmd == CMD_RAW) begin
          sr_d    = {cmd_q.raw_address, raw_al};
          bits_d  = BITCNT_W'({raw_cnt, 3'b000}) + BITCNT_W'(8);
          upd_d   = cmd_q.raw_update;
          final_d = 1'b1;
        end else begin
          sr_d    = {REG_CHAN_SEL, cmd_q.channel_select, 24'h0};
          bits_d  = BITS_CHAN;
          upd_d   = 1'b1;
          final_d = 1'b0;
        end
      end else begin
        upd_d   = 1'b1;
        final_d = 1'b1;
        unique case (cmd_q.cmd)
          CMD_FREQ: begin
            sr_d   = {REG_FREQ_WORD, tw};
            bits_d = BITS_FREQ;
          end
          CMD_PHASE: begin
            sr_d   = {REG_PHASE_WORD, 2'b00, cmd_q.phase_word, 16'h0};
            bits_d = BITS_PHASE;
          end
          default: begin
            sr_d   = {REG_AMPL_CTRL, 8'h00, ampl_val, 8'h00};
            bits_d = BITS_AMPL;
          end
        endcase
      end
    end else if (ctrl_i.shift) begin
      sr_d    = {sr_q[FRAME_W-2:0], 1'b0};
      bits_d  = bits_q - BITCNT_W'(1);
      first_d = 1'b0;
    end
    if (ctrl_i.shift) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bits_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      bits_q      <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q    <= sr_d;
    first_q <= first_d;
    upd_q   <= upd_d;
    final_q <= final_d;
    if (ctrl_i.shift) begin
      out_bit_q   <= sr_q[FRAME_W-1];
      out_start_q <= first_q;
      out_end_q   <= stat_o.last_bit;
      out_upd_q   <= stat_o.last_bit & upd_q;
      out_last_q  <= stat_o.last_bit & final_q;
    end
  end

  assign stat_o.last_bit = (bits_q == BITCNT_W'(1));
  assign stat_o.is_raw   = (cmd_q.cmd == CMD_RAW);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;
  assign out_upd_o   = out_upd_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/dcs_ctrl.sv @@
// frame sequencing state machine
// depends on dcs_pkg
`default_nettype none

module dcs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dcs_pkg::dcs_stat_t stat_i,
  output dcs_pkg::dcs_ctrl_t      ctrl_o
);
  import dcs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    ctrl_o.load_cmd   = 1'b0;
    ctrl_o.load_frame = 1'b0;
    ctrl_o.sel        = FRAME_FIRST;
    ctrl_o.shift      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        ctrl_o.load_cmd = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOAD1;
        end
      end
      ST_LOAD1: begin
        ctrl_o.load_frame = 1'b1;
        state_d           = ST_SEND1;
      end
      ST_SEND1: begin
        ctrl_o.shift = stat_i.out_free;
        if (stat_i.out_free && stat_i.last_bit) begin
          state_d = stat_i.is_raw ? ST_IDLE : ST_LOAD2;
        end
      end
      ST_LOAD2: begin
        // tuning word must be finished before the value frame is built
        ctrl_o.sel = FRAME_SECOND;
        if (stat_i.div_done) begin
          ctrl_o.load_frame = 1'b1;
          state_d           = ST_SEND2;
        end
      end
      ST_SEND2: begin
        ctrl_o.shift = stat_i.out_free;
        if (stat_i.out_free && stat_i.last_bit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dds_command_serializer_core.sv @@
// dds command serializer: turns one command into serial register-write bits
// depends on dcs_pkg, dcs_ctrl, dcs_datapath and the defines header
//
// slave channel: one command per transfer, the kind in tuser, fields in tdata.
// master channel: one serial data bit per transfer, msb first, with frame
// start, frame end and update flags in tuser and tlast on the command's
// final bit.
// frequency, phase and amplitude commands send a channel select frame of 16
// bits and then a value frame of 40, 24 or 32 bits; a raw write sends one
// frame of 8 plus 8 per data byte.
// after the command transfer the state machine loads the first frame and then
// shifts its first bit into the output register. one bit leaves the frame
// shifter per cycle while the receiver takes bits; a raw write then returns to
// idle, while a two-frame command loads and sends its value frame first.
// the tuning word is built from three slice products against a fixed
// reciprocal and is ready long before the value frame is built.
// a new command is taken once the last bit sits in the output register.
// when the receiver stalls the output register holds and the shifter waits.
// reset clears the state machine, the divider step count, the frame bit count
// and the output valid flag; nothing else needs clearing.
`default_nettype none

`include "dds_command_serializer_core_defines.svh"

module dds_command_serializer_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // channel_select[7:0], frequency_hz[35:8], phase_word[49:36],
  // amplitude_word[59:50], raw_address[67:60], raw_byte_count[70:68],
  // raw_data[102:71], raw_update[103]
  input  wire logic [103:0] s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // data_bit[0], zero fill [7:1]
  output logic [7:0]        m_axis_tdata,
  // frame_start[0], frame_end[1], update_pulse[2]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import dcs_pkg::*;

  dcs_cmd_t  cmd;
  dcs_ctrl_t ctrl;
  dcs_stat_t stat;
  logic      out_bit;

  assign cmd.cmd            = cmd_e'(s_axis_tuser);
  assign cmd.channel_select = s_axis_tdata[7:0];
  assign cmd.frequency_hz   = s_axis_tdata[35:8];
  assign cmd.phase_word     = s_axis_tdata[49:36];
  assign cmd.amplitude_word = s_axis_tdata[59:50];
  assign cmd.raw_address    = s_axis_tdata[67:60];
  assign cmd.raw_byte_count = s_axis_tdata[70:68];
  assign cmd.raw_data       = s_axis_tdata[102:71];
  assign cmd.raw_update     = s_axis_tdata[103];

  dcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  dcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_bit_o   (out_bit),
    .out_start_o (m_axis_tuser[0]),
    .out_end_o   (m_axis_tuser[1]),
    .out_upd_o   (m_axis_tuser[2]),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'b0, out_bit};

  `DCS_ASSERT_NEXT(a_busy_after_cmd, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "block ready right after taking a command")
  `DCS_ASSERT_NOW(a_value_frame_after_div, ctrl.load_frame && (ctrl.sel == FRAME_SECOND),
                  stat.div_done, "value frame built before tuning word finished")
  `DCS_ASSERT_NOW(a_last_ends_frame, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1],
                  "final bit not at a frame end")
  `DCS_ASSERT_NOW(a_update_at_end, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1],
                  "update flag away from a frame end")

endmodule

`default_nettype wire
